>>> rtl/pls_pkg.sv
// pls_pkg: shared types, sizes and codes of the positional list store.
// No dependencies; every other file of the block refers to it by scoped names.
package pls_pkg;

  // Storage size.
  localparam int CAPACITY = 1024;

  // Field widths.
  localparam int KIND_W   = 3;
  localparam int POS_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 11;

  // Element count register holds 0 .. CAPACITY.
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  // Comparison width wide enough for any position and any count.
  localparam int CMP_W   = 17;

  // Read tree: groups of cells, one mux level per registered stage.
  localparam int GROUP_W    = 5;
  localparam int GROUP      = 1 << GROUP_W;
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
  localparam int GSEL_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int SEL_EXT_W  = 16;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] elem_t;

  localparam elem_t NO_VALUE = -32'sd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    elem_t             value;
  } in_item_t;

  typedef struct packed {
    elem_t               read_value;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    length;
  } out_item_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
    elem_t            value;
  } cell_ctrl_t;

endpackage

>>> rtl/pls_cell.sv
// pls_cell: one storage cell of the element chain.
// Depends on pls_pkg for the element type and the broadcast control struct.
module pls_cell (
  input  logic                      clk,
  input  pls_pkg::cell_ctrl_t       ctrl,
  input  logic [pls_pkg::CMP_W-1:0] idx,
  input  pls_pkg::elem_t            left,
  input  pls_pkg::elem_t            right,
  output pls_pkg::elem_t            data
);

  // Insert: take the new value at the insert point, shift up above it.
  // Delete: pull down from the right neighbour at and above the point.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx == ctrl.pos) begin
        data <= ctrl.value;
      end else if (idx > ctrl.pos) begin
        data <= left;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pos) begin
        data <= right;
      end
    end
  end

endmodule

>>> rtl/pls_read_tree.sv
// pls_read_tree: two-stage registered mux that picks one cell for a read.
// Depends on pls_pkg for sizes and the element type.
module pls_read_tree (
  input  logic                      clk,
  input  logic                      load,
  input  logic [pls_pkg::POS_W-1:0] pos,
  input  pls_pkg::elem_t            cells [pls_pkg::CAPACITY],
  output pls_pkg::elem_t            data
);

  logic [pls_pkg::SEL_EXT_W-1:0] pos_x;
  logic [pls_pkg::GROUP_W-1:0]   lo;
  logic [pls_pkg::GSEL_W-1:0]    hi;
  pls_pkg::elem_t                stage1 [pls_pkg::NUM_GROUPS];

  assign pos_x = pls_pkg::SEL_EXT_W'(pos);
  assign lo    = pos_x[pls_pkg::GROUP_W-1:0];

  for (genvar g = 0; g < pls_pkg::NUM_GROUPS; g++) begin : g_group
    pls_pkg::elem_t grp [pls_pkg::GROUP];
    for (genvar k = 0; k < pls_pkg::GROUP; k++) begin : g_leaf
      if (g * pls_pkg::GROUP + k < pls_pkg::CAPACITY) begin : g_real
        assign grp[k] = cells[g * pls_pkg::GROUP + k];
      end else begin : g_pad
        assign grp[k] = '0;
      end
    end

    // First level: pick within the group.
    always_ff @(posedge clk) begin
      if (load) begin
        stage1[g] <= grp[lo];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hi <= pos_x[pls_pkg::GROUP_W +: pls_pkg::GSEL_W];
    end
  end

  // Second level: pick the group; holds while stage one holds.
  always_ff @(posedge clk) begin
    data <= stage1[hi];
  end

endmodule

>>> rtl/positional_list_store.sv
// positional_list_store: ordered list of signed 32-bit values kept in a chain of cells.
// Depends on pls_pkg, pls_cell and pls_read_tree.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_stall | in_data  (kind, position, value)
//   out     | out_valid/out_stall | out_data (read_value, status, length)
//
// Operations: insert and delete move every cell on the same edge; unknown kinds
//   change nothing. A read passes through the two registered levels of the read
//   mux tree into the output register; input stalls meanwhile.
// Reset: clears the element count and all valid flags; cell contents are
//   left as they are, since only positions below the count are ever read.
// Stalls: a read in the tree stalls the input, and so does a held result that is not being taken.
module positional_list_store (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pls_pkg::out_item_t out_data
);

  logic [pls_pkg::COUNT_W-1:0] count;
  logic [pls_pkg::COUNT_W-1:0] count_next;

  // Read pipeline flags and the result fields carried alongside.
  logic                         s1_valid;
  logic                         s2_valid;
  logic                         rd_ok;
  logic [pls_pkg::LEN_W-1:0]    rd_len;
  pls_pkg::elem_t               rd_data;

  logic accept;
  logic out_free;
  logic is_read;
  logic is_ins;
  logic is_del;
  logic ins_bad;
  logic ins_full;
  logic del_bad;
  logic rd_ok_now;
  logic [pls_pkg::CMP_W-1:0]    pos_w;
  logic [pls_pkg::CMP_W-1:0]    cnt_w;
  logic [pls_pkg::CMP_W-1:0]    ins_pos;
  logic [pls_pkg::STATUS_W-1:0] status_now;

  pls_pkg::cell_ctrl_t ctrl;
  pls_pkg::elem_t      cell_data [pls_pkg::CAPACITY];

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid || s2_valid || !out_free;
  assign accept   = in_valid && !in_stall;

  assign pos_w = pls_pkg::CMP_W'(in_data.position);
  assign cnt_w = pls_pkg::CMP_W'(count);

  always_comb begin
    is_read = 1'b0;
    is_ins  = 1'b0;
    is_del  = 1'b0;
    ins_pos = pos_w;
    case (in_data.kind)
      pls_pkg::KIND_READ: begin
        is_read = 1'b1;
      end
      pls_pkg::KIND_INS_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      pls_pkg::KIND_INS_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_w;
      end
      pls_pkg::KIND_INS_AT: begin
        is_ins = 1'b1;
      end
      pls_pkg::KIND_DELETE: begin
        is_del = 1'b1;
      end
      default: begin
        // Unknown kinds change nothing.
      end
    endcase
  end

  // Position check comes before the full check.
  assign ins_bad   = ins_pos > cnt_w;
  assign ins_full  = cnt_w == pls_pkg::CMP_W'(pls_pkg::CAPACITY);
  assign del_bad   = pos_w >= cnt_w;
  assign rd_ok_now = pos_w < cnt_w;

  always_comb begin
    status_now = pls_pkg::STATUS_DONE;
    count_next = count;
    if (is_ins) begin
      if (ins_bad) begin
        status_now = pls_pkg::STATUS_RANGE;
      end else if (ins_full) begin
        status_now = pls_pkg::STATUS_FULL;
      end else begin
        count_next = count + pls_pkg::COUNT_W'(1);
      end
    end else if (is_del) begin
      if (del_bad) begin
        status_now = pls_pkg::STATUS_RANGE;
      end else begin
        count_next = count - pls_pkg::COUNT_W'(1);
      end
    end
  end

  // Broadcast the move to every cell.
  always_comb begin
    ctrl.ins   = accept && is_ins && !ins_bad && !ins_full;
    ctrl.del   = accept && is_del && !del_bad;
    ctrl.pos   = ins_pos;
    ctrl.value = in_data.value;
  end

  for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_chain
    pls_pkg::elem_t left;
    pls_pkg::elem_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == pls_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    pls_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (pls_pkg::CMP_W'(i)),
      .left  (left),
      .right (right),
      .data  (cell_data[i])
    );
  end

  pls_read_tree u_read_tree (
    .clk   (clk),
    .load  (accept && is_read),
    .pos   (in_data.position),
    .cells (cell_data),
    .data  (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      // Advance the read through the tree; hold at the end until the
      // output register frees up.
      s1_valid <= accept && is_read;
      if (s1_valid) begin
        s2_valid <= 1'b1;
      end else if (s2_valid && out_free) begin
        s2_valid <= 1'b0;
      end
      if ((accept && !is_read) || (s2_valid && out_free)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Read side fields, captured at accept.
  always_ff @(posedge clk) begin
    if (accept && is_read) begin
      rd_ok  <= rd_ok_now;
      rd_len <= pls_pkg::LEN_W'(count);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept && !is_read) begin
      out_data.read_value <= pls_pkg::NO_VALUE;
      out_data.status     <= status_now;
      out_data.length     <= pls_pkg::LEN_W'(count_next);
    end else if (s2_valid && out_free) begin
      out_data.read_value <= rd_ok ? rd_data : pls_pkg::NO_VALUE;
      out_data.status     <= rd_ok ? pls_pkg::STATUS_DONE : pls_pkg::STATUS_RANGE;
      out_data.length     <= rd_len;
    end
  end

endmodule

>>> rtl/pls_checker.sv
// pls_checker: port-level checks of the positional list store, bound to the top level.
// Depends on pls_pkg and positional_list_store.
module pls_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input pls_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pls_pkg::out_item_t out_data
);

  // Length never exceeds the capacity.
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.length <= pls_pkg::LEN_W'(pls_pkg::CAPACITY)))
    else $error("length above capacity");

  // A dropped insert is only reported when the store is full.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == pls_pkg::STATUS_FULL) |->
      (out_data.length == pls_pkg::LEN_W'(pls_pkg::CAPACITY)))
    else $error("full status with store not full");

  // A failed operation never returns data.
  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != pls_pkg::STATUS_DONE) |->
      (out_data.read_value == pls_pkg::NO_VALUE))
    else $error("failed operation returned data");

  // An accepted head insert with no result held yields a result that failed or shows a non-zero length.
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid &&
      (in_data.kind == pls_pkg::KIND_INS_HEAD) |=>
      out_valid && ((out_data.status != pls_pkg::STATUS_DONE) ||
                    (out_data.length != '0)))
    else $error("insert left an empty store");

  // Held result stays put while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind positional_list_store pls_checker u_pls_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
